// ----- design/rmq_pkg.sv -----
// Shared types for the rotation-matrix-to-quaternion unit.
// No dependencies; compiled first.
package rmq_pkg;

    // Which Shepperd branch supplies the square root.
    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } t_branch;

endpackage

// ----- design/rmq_if.sv -----
// Valid/ready channel interfaces for matrix input and quaternion output.
// Depends on nothing; compiled after rmq_pkg.
interface rmq_in_if #(parameter int DATA_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    modport source (output valid, output m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink   (input valid, input m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    output ready);
endinterface

interface rmq_out_if #(parameter int DATA_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] quat_w, quat_x, quat_y, quat_z;
    logic                         bad_matrix;

    modport source (output valid, output quat_w, quat_x, quat_y, quat_z, bad_matrix,
                    input ready);
    modport sink   (input valid, input quat_w, quat_x, quat_y, quat_z, bad_matrix,
                    output ready);
endinterface

// ----- design/rotation_matrix_to_quaternion_unit.sv -----
// Rotation matrix to quaternion (Shepperd), fixed point, fully pipelined.
// Throughput: one transfer per cycle while the output is not stalled. Stages run input register,
// sums, branch select, square root (RW, the root width, one root bit per stage), divider
// setup, division (NW, the quotient width, one bit per stage) and output. Synchronous
// active-low reset clears all valid bits; payload registers are not reset.
module rotation_matrix_to_quaternion_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rmq_in_if.sink    i_mat,
    rmq_out_if.source o_quat
);
    import rmq_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int F   = FRAC_BITS;
    // Signed width that holds any trace or branch argument exactly.
    localparam int AW  = ((W > F + 1) ? W : F + 1) + 3;
    // Radicand arg << F, padded to an even width so the root takes two bits per step.
    localparam int XW0 = AW - 1 + F;
    localparam int XW  = XW0 + (XW0 % 2);
    localparam int RW  = XW / 2;
    // Dividend (|d| << F) + s and quotient width.
    localparam int NW  = ((W + 1 + F > RW) ? W + 1 + F : RW) + 1;

    localparam logic signed [AW-1:0] ONE_FX = {{(AW-1){1'b0}}, 1'b1} << F;
    localparam logic [NW-1:0]        SAT_HI = ({{(NW-1){1'b0}}, 1'b1} << (W - 1)) - 1'b1;
    localparam logic [NW-1:0]        SAT_LO = {{(NW-1){1'b0}}, 1'b1} << (W - 1);

    typedef logic signed [W-1:0]  t_ent;
    typedef logic signed [W:0]    t_dif;
    typedef logic signed [AW-1:0] t_arg;

    // Payload carried through the square-root stages.
    typedef struct packed {
        t_branch             br;
        logic                bad;
        logic [2:0][W:0]     d;
        logic [XW-1:0]       x;
        logic [RW+1:0]       rem;
        logic [RW-1:0]       root;
    } t_sq;

    // Payload carried through the divider stages; three lanes share one divisor.
    typedef struct packed {
        t_branch             br;
        logic                bad;
        logic [RW-1:0]       diag;
        logic [RW:0]         dvs;
        logic [2:0]          neg;
        logic [2:0][NW-1:0]  n;
        logic [2:0][RW:0]    rem;
        logic [2:0][NW-1:0]  q;
    } t_dv;

    // The whole pipe advances together; a stall freezes every stage.
    logic r_vout;
    logic en;
    assign en          = ~r_vout | o_quat.ready;
    assign i_mat.ready = en;

    // ---------------- stage 0: input register ----------------
    logic r_v0;
    t_ent r_m [9];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_mat.valid;
        end
        if (en) begin
            r_m[0] <= i_mat.m00; r_m[1] <= i_mat.m01; r_m[2] <= i_mat.m02;
            r_m[3] <= i_mat.m10; r_m[4] <= i_mat.m11; r_m[5] <= i_mat.m12;
            r_m[6] <= i_mat.m20; r_m[7] <= i_mat.m21; r_m[8] <= i_mat.m22;
        end
    end

    // ---------------- stage 1: sums, candidate arguments, compares ----------------
    logic r_v1;
    t_arg r_tr, r_at, r_a0, r_a1, r_a2;
    logic r_gt10, r_gt20, r_gt21;
    t_dif r_p01, r_p02, r_p12, r_n0, r_n1, r_n2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= r_v0;
        end
        if (en) begin
            r_tr   <= t_arg'(r_m[0]) + t_arg'(r_m[4]) + t_arg'(r_m[8]);
            r_at   <= t_arg'(r_m[0]) + t_arg'(r_m[4]) + t_arg'(r_m[8]) + ONE_FX;
            r_a0   <= t_arg'(r_m[0]) - t_arg'(r_m[4]) - t_arg'(r_m[8]) + ONE_FX;
            r_a1   <= t_arg'(r_m[4]) - t_arg'(r_m[8]) - t_arg'(r_m[0]) + ONE_FX;
            r_a2   <= t_arg'(r_m[8]) - t_arg'(r_m[0]) - t_arg'(r_m[4]) + ONE_FX;
            r_gt10 <= r_m[4] > r_m[0];
            r_gt20 <= r_m[8] > r_m[0];
            r_gt21 <= r_m[8] > r_m[4];
            r_p01  <= t_dif'(r_m[1]) + t_dif'(r_m[3]);
            r_p02  <= t_dif'(r_m[6]) + t_dif'(r_m[2]);
            r_p12  <= t_dif'(r_m[5]) + t_dif'(r_m[7]);
            r_n0   <= t_dif'(r_m[7]) - t_dif'(r_m[5]);
            r_n1   <= t_dif'(r_m[2]) - t_dif'(r_m[6]);
            r_n2   <= t_dif'(r_m[3]) - t_dif'(r_m[1]);
        end
    end

    // ---------------- stage 2: branch select, error check, radicand ----------------
    // Lanes hold the three non-diagonal components in w, x, y, z order.
    t_branch br_sel;
    t_arg    arg_sel;
    logic    bad_sel;
    t_sq     sq_in;

    always_comb begin
        sq_in = '0;
        if (!r_tr[AW-1]) begin
            br_sel  = BR_TRACE;
            arg_sel = r_at;
        end else if (r_gt10 ? r_gt21 : r_gt20) begin
            br_sel  = BR_Z;
            arg_sel = r_a2;
        end else if (r_gt10) begin
            br_sel  = BR_Y;
            arg_sel = r_a1;
        end else begin
            br_sel  = BR_X;
            arg_sel = r_a0;
        end
        bad_sel = arg_sel[AW-1] | (arg_sel == '0);
        unique case (br_sel)
            BR_TRACE: sq_in.d = {r_n2, r_n1, r_n0};
            BR_X:     sq_in.d = {r_p02, r_p01, r_n0};
            BR_Y:     sq_in.d = {r_p12, r_p01, r_n1};
            BR_Z:     sq_in.d = {r_p12, r_p02, r_n2};
            default:  sq_in.d = '0;
        endcase
        sq_in.br  = br_sel;
        sq_in.bad = bad_sel;
        // A bad matrix still runs with a harmless radicand so the divisor is nonzero.
        sq_in.x   = bad_sel ? (XW'(1) << F) : (XW'(arg_sel[AW-2:0]) << F);
    end

    // ---------------- square root: one root bit per stage ----------------
    logic r_vsq [RW+1];
    t_sq  r_sq  [RW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vsq[0] <= 1'b0;
        end else if (en) begin
            r_vsq[0] <= r_v1;
        end
        if (en) begin
            r_sq[0] <= sq_in;
        end
    end

    for (genvar i = 0; i < RW; i++) begin : g_sqrt
        logic [RW+3:0] trial, tsub;
        t_sq           n_sq;

        always_comb begin
            n_sq  = r_sq[i];
            trial = {r_sq[i].rem, r_sq[i].x[XW-1:XW-2]};
            tsub  = {2'b00, r_sq[i].root, 2'b01};
            n_sq.x = r_sq[i].x << 2;
            if (trial >= tsub) begin
                n_sq.rem  = (RW+2)'(trial - tsub);
                n_sq.root = {r_sq[i].root[RW-2:0], 1'b1};
            end else begin
                n_sq.rem  = trial[RW+1:0];
                n_sq.root = {r_sq[i].root[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vsq[i+1] <= 1'b0;
            end else if (en) begin
                r_vsq[i+1] <= r_vsq[i];
            end
            if (en) begin
                r_sq[i+1] <= n_sq;
            end
        end
    end

    // ---------------- divider setup: dividend (|d| << F) + s, divisor 2s ----------------
    t_dv dv_in;

    always_comb begin
        logic [W:0] mag;
        dv_in      = '0;
        dv_in.br   = r_sq[RW].br;
        dv_in.bad  = r_sq[RW].bad;
        dv_in.diag = r_sq[RW].root >> 1;
        dv_in.dvs  = {r_sq[RW].root, 1'b0};
        for (int l = 0; l < 3; l++) begin
            dv_in.neg[l] = r_sq[RW].d[l][W];
            mag          = r_sq[RW].d[l][W] ? (~r_sq[RW].d[l] + 1'b1) : r_sq[RW].d[l];
            dv_in.n[l]   = (NW'(mag) << F) + NW'(r_sq[RW].root);
        end
    end

    logic r_vdv [NW+1];
    t_dv  r_dv  [NW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vdv[0] <= 1'b0;
        end else if (en) begin
            r_vdv[0] <= r_vsq[RW];
        end
        if (en) begin
            r_dv[0] <= dv_in;
        end
    end

    // ---------------- restoring division: one quotient bit per stage ----------------
    for (genvar j = 0; j < NW; j++) begin : g_div
        t_dv n_dv;

        always_comb begin
            logic [RW+1:0] trial;
            n_dv = r_dv[j];
            for (int l = 0; l < 3; l++) begin
                trial       = {r_dv[j].rem[l], r_dv[j].n[l][NW-1]};
                n_dv.n[l]   = r_dv[j].n[l] << 1;
                if (trial >= {1'b0, r_dv[j].dvs}) begin
                    n_dv.rem[l] = (RW+1)'(trial - {1'b0, r_dv[j].dvs});
                    n_dv.q[l]   = {r_dv[j].q[l][NW-2:0], 1'b1};
                end else begin
                    n_dv.rem[l] = trial[RW:0];
                    n_dv.q[l]   = {r_dv[j].q[l][NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vdv[j+1] <= 1'b0;
            end else if (en) begin
                r_vdv[j+1] <= r_vdv[j];
            end
            if (en) begin
                r_dv[j+1] <= n_dv;
            end
        end
    end

    // ---------------- output: sign, saturation, component placement ----------------
    function automatic logic [W-1:0] sat(input logic neg, input logic [NW-1:0] q);
        logic [NW-1:0] nq;
        nq = ~q + 1'b1;
        if (!neg) begin
            return (q > SAT_HI) ? SAT_HI[W-1:0] : q[W-1:0];
        end else begin
            return (q >= SAT_LO) ? SAT_LO[W-1:0] : nq[W-1:0];
        end
    endfunction

    logic [W-1:0] dg, l0, l1, l2;
    logic [W-1:0] n_w, n_x, n_y, n_z;
    logic [W-1:0] r_w, r_x, r_y, r_z;
    logic         r_bad;

    always_comb begin
        dg = sat(1'b0, NW'(r_dv[NW].diag));
        l0 = sat(r_dv[NW].neg[0], r_dv[NW].q[0]);
        l1 = sat(r_dv[NW].neg[1], r_dv[NW].q[1]);
        l2 = sat(r_dv[NW].neg[2], r_dv[NW].q[2]);
        unique case (r_dv[NW].br)
            BR_TRACE: begin n_w = dg; n_x = l0; n_y = l1; n_z = l2; end
            BR_X:     begin n_w = l0; n_x = dg; n_y = l1; n_z = l2; end
            BR_Y:     begin n_w = l0; n_x = l1; n_y = dg; n_z = l2; end
            BR_Z:     begin n_w = l0; n_x = l1; n_y = l2; n_z = dg; end
            default:  begin n_w = '0; n_x = '0; n_y = '0; n_z = '0; end
        endcase
        if (r_dv[NW].bad) begin
            n_w = '0; n_x = '0; n_y = '0; n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vout <= 1'b0;
        end else if (en) begin
            r_vout <= r_vdv[NW];
        end
        if (en) begin
            r_w   <= n_w;
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_bad <= r_dv[NW].bad;
        end
    end

    assign o_quat.valid      = r_vout;
    assign o_quat.quat_w     = r_w;
    assign o_quat.quat_x     = r_x;
    assign o_quat.quat_y     = r_y;
    assign o_quat.quat_z     = r_z;
    assign o_quat.bad_matrix = r_bad;

endmodule
